// File: design/pls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the priority load shedder
// Request codes, sequencer states, register map and the config bundle.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int MAX_CHANNELS     = 8;

	// field widths
	localparam int REQ_W    = 2;
	localparam int CHAN_W   = 3;
	localparam int POWER_W  = 16;
	localparam int MASK_W   = 8;
	localparam int COUNT_W  = 4;
	localparam int DEMAND_W = 15;
	localparam int BYTE_W   = 8;
	localparam int TERM_W   = 12;   // byte * 10 mA
	localparam int WATT_W   = 18;   // demand * 5 V

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [BYTE_W-1:0] NEVER_SHED = 8'hFF;

	localparam logic [APB_DATA_W-1:0] CUR_LO_RST = 32'h0A141E0F;
	localparam logic [APB_DATA_W-1:0] CUR_HI_RST = 32'h321E0F32;
	localparam logic [APB_DATA_W-1:0] PRI_LO_RST = 32'h0607090A;
	localparam logic [APB_DATA_W-1:0] PRI_HI_RST = 32'h02050403;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENABLE  = 2'd0,
		REQ_DISABLE = 2'd1,
		REQ_SHED    = 2'd2,
		REQ_STATUS  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		REG_CUR_LO = 2'd0,
		REG_CUR_HI = 2'd1,
		REG_PRI_LO = 2'd2,
		REG_PRI_HI = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CHECK,
		ST_SEARCH,
		ST_APPLY,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [APB_DATA_W-1:0] cur_lo;
		logic [APB_DATA_W-1:0] cur_hi;
		logic [APB_DATA_W-1:0] pri_lo;
		logic [APB_DATA_W-1:0] pri_hi;
	} cfg_t;

endpackage

// File: design/pls_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_regs: APB register file
// Per-channel demand and priority bytes, four 32-bit registers.
// ----------------------------------------------------------------------------
module pls_regs
	import pls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cur_lo <= CUR_LO_RST;
			cfg_q.cur_hi <= CUR_HI_RST;
			cfg_q.pri_lo <= PRI_LO_RST;
			cfg_q.pri_hi <= PRI_HI_RST;
		end else if (wr_en) begin
			case (idx)
				REG_CUR_LO: cfg_q.cur_lo <= pwdata;
				REG_CUR_HI: cfg_q.cur_hi <= pwdata;
				REG_PRI_LO: cfg_q.pri_lo <= pwdata;
				REG_PRI_HI: cfg_q.pri_hi <= pwdata;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CUR_LO: prdata = cfg_q.cur_lo;
			REG_CUR_HI: prdata = cfg_q.cur_hi;
			REG_PRI_LO: prdata = cfg_q.pri_lo;
			REG_PRI_HI: prdata = cfg_q.pri_hi;
			default:    prdata = '0;
		endcase
	end

endmodule

// File: design/pls_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_engine: sequencer and shared add/compare unit
// Walks the channels one per cycle for demand sums and min-priority search.
// ----------------------------------------------------------------------------
module pls_engine
	import pls_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [CHAN_W-1:0]   channel,
	input  logic [POWER_W-1:0]  available_power_mw,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [MASK_W-1:0]   enabled_mask,
	output logic [COUNT_W-1:0]  active_count,
	output logic [DEMAND_W-1:0] demand_ma,
	output logic [MASK_W-1:0]   shed_mask,
	output logic                budget_met
);

	localparam int IDX_W  = $clog2(NUM_CHANNELS);
	localparam int PASS_W = $clog2(NUM_CHANNELS + 1);
	localparam logic [IDX_W-1:0]        IDX_LAST  = IDX_W'(NUM_CHANNELS - 1);
	localparam logic [IDX_W-1:0]        IDX_FIRST = IDX_W'(1);
	localparam logic [PASS_W-1:0]       PASS_MAX  = PASS_W'(NUM_CHANNELS);
	localparam logic [CHAN_W:0]         CHAN_LIM  = (CHAN_W + 1)'(NUM_CHANNELS);
	localparam logic [NUM_CHANNELS-1:0] EN_RST    = NUM_CHANNELS'(15);

	state_t state_q, state_d;

	logic [NUM_CHANNELS-1:0] en_q;
	logic [NUM_CHANNELS-1:0] shed_q;
	logic                    out_valid_q;
	req_t                    req_q;
	logic [POWER_W-1:0]      power_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        pick_q;
	logic [BYTE_W-1:0]       low_q;
	logic                    found_q;
	logic [PASS_W-1:0]       pass_q;
	logic [DEMAND_W-1:0]     demand_q;
	logic [COUNT_W-1:0]      count_q;

	logic [MASK_W-1:0]   out_mask_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [DEMAND_W-1:0] out_demand_q;
	logic [MASK_W-1:0]   out_shed_q;
	logic                out_met_q;

	logic [BYTE_W-1:0] cur_a [NUM_CHANNELS];
	logic [BYTE_W-1:0] pri_a [NUM_CHANNELS];

	logic                    in_fire;
	logic                    out_free;
	logic                    out_load;
	logic                    ch_ok;
	logic [NUM_CHANNELS-1:0] ch_bit;
	logic [NUM_CHANNELS-1:0] pick_bit;
	logic [IDX_W-1:0]        sel_idx;
	logic [BYTE_W-1:0]       sel_cur;
	logic [DEMAND_W-1:0]     term;
	logic [DEMAND_W-1:0]     acc_out;
	logic [WATT_W-1:0]       watts;
	logic                    over;
	logic                    hit;

	// unpack per-channel bytes
	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			cur_a[i] = (i < 4) ? cfg.cur_lo[8*(i%4) +: 8] : cfg.cur_hi[8*(i%4) +: 8];
			pri_a[i] = (i < 4) ? cfg.pri_lo[8*(i%4) +: 8] : cfg.pri_hi[8*(i%4) +: 8];
		end
	end

	// shared unit: add or subtract one channel's demand, compare one priority
	assign sel_idx = (state_q == ST_APPLY) ? pick_q : idx_q;
	assign sel_cur = cur_a[sel_idx];
	assign term    = DEMAND_W'({sel_cur, 3'b000}) + DEMAND_W'({sel_cur, 1'b0});
	assign acc_out = (state_q == ST_APPLY) ? (demand_q - term) : (demand_q + term);
	assign hit     = en_q[idx_q] && (pri_a[idx_q] < low_q);

	assign watts = WATT_W'({demand_q, 2'b00}) + WATT_W'(demand_q);
	assign over  = watts > WATT_W'(power_q);

	assign ch_ok    = {1'b0, channel} < CHAN_LIM;
	assign ch_bit   = NUM_CHANNELS'(1) << channel[IDX_W-1:0];
	assign pick_bit = NUM_CHANNELS'(1) << pick_q;

	assign out_free = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SUM;
			ST_SUM:    if (idx_q == IDX_LAST) state_d = ST_CHECK;
			ST_CHECK: begin
				if (req_q == REQ_SHED && over && pass_q < PASS_MAX) state_d = ST_SEARCH;
				else state_d = ST_FINISH;
			end
			ST_SEARCH: begin
				if (idx_q == IDX_LAST) state_d = (hit || found_q) ? ST_APPLY : ST_FINISH;
			end
			ST_APPLY:  state_d = ST_CHECK;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_FINISH: out_load = out_free;
			default: begin
				in_ready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			en_q        <= EN_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && ch_ok) begin
				if (req_type == REQ_ENABLE) en_q <= en_q | ch_bit;
				else if (req_type == REQ_DISABLE && channel != '0) en_q <= en_q & ~ch_bit;
			end
			if (state_q == ST_APPLY) en_q <= en_q & ~pick_bit;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q    <= req_t'(req_type);
				power_q  <= available_power_mw;
				idx_q    <= '0;
				pass_q   <= '0;
				demand_q <= '0;
				count_q  <= '0;
				shed_q   <= '0;
			end
			ST_SUM: begin
				if (en_q[idx_q]) begin
					demand_q <= acc_out;
					count_q  <= count_q + COUNT_W'(1);
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			ST_CHECK: begin
				idx_q   <= IDX_FIRST;
				low_q   <= NEVER_SHED;
				found_q <= 1'b0;
			end
			ST_SEARCH: begin
				if (hit) begin
					low_q   <= pri_a[idx_q];
					pick_q  <= idx_q;
					found_q <= 1'b1;
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			ST_APPLY: begin
				demand_q <= acc_out;
				count_q  <= count_q - COUNT_W'(1);
				shed_q   <= shed_q | pick_bit;
				pass_q   <= pass_q + PASS_W'(1);
			end
			ST_FINISH: begin
				if (out_load) begin
					out_mask_q   <= MASK_W'(en_q);
					out_count_q  <= count_q;
					out_demand_q <= demand_q;
					out_shed_q   <= MASK_W'(shed_q);
					out_met_q    <= !over;
				end
			end
			default: idx_q <= idx_q;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign enabled_mask = out_mask_q;
	assign active_count = out_count_q;
	assign demand_ma    = out_demand_q;
	assign shed_mask    = out_shed_q;
	assign budget_met   = out_met_q;

endmodule

// File: design/priority_load_shedder_unit.sv
// Enable, disable and status beats: the sequencer sums demand over all channels
// (N = NUM_CHANNELS, one channel per cycle through the shared adder) and checks the budget.
// A shed then runs passes (min-priority scan, apply, budget check), up to N passes.
// One request at a time: s_tready is high only while the sequencer is idle, so the
// next beat is taken only after the last result beat has entered the output register.
// Reset (arst_n, async, active low): channels 0 to 3 on, registers at defaults.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_load_shedder_unit: channel power switch with priority shedding
// Stream request in, stream status out, APB register port for demand/priority.
// ----------------------------------------------------------------------------
module priority_load_shedder_unit
	import pls_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// request beats
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // req_type, channel, available_power_mw, pad
	// result beats
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // enabled_mask, active_count, demand_ma,
	                                        // shed_mask, budget_met, pad
);

	cfg_t cfg;

	logic [MASK_W-1:0]   enabled_mask;
	logic [COUNT_W-1:0]  active_count;
	logic [DEMAND_W-1:0] demand_ma;
	logic [MASK_W-1:0]   shed_mask;
	logic                budget_met;

	// demand and priority bytes
	pls_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer plus shared add/compare unit; holds the enable mask and the
	// output register, so a finished beat waits there while m_tready is low
	pls_engine #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_engine (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.in_valid           (s_tvalid),
		.in_ready           (s_tready),
		.req_type           (s_tdata[1:0]),
		.channel            (s_tdata[4:2]),
		.available_power_mw (s_tdata[20:5]),
		.out_valid          (m_tvalid),
		.out_ready          (m_tready),
		.enabled_mask       (enabled_mask),
		.active_count       (active_count),
		.demand_ma          (demand_ma),
		.shed_mask          (shed_mask),
		.budget_met         (budget_met)
	);

	// pack result fields, lowest first, pad to whole bytes
	assign m_tdata = {4'b0000, budget_met, shed_mask, demand_ma, active_count, enabled_mask};

endmodule
